### hdl/htid_pkg.sv
// shared types, constants and helpers for the hilbert tile id pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package htid_pkg;

    localparam int ZOOM_W   = 5;
    localparam int COORD_W  = 31;
    localparam int ID_W     = 63;
    localparam int SUM_W    = 64;
    localparam int STAGES   = 4;
    localparam logic [ID_W-1:0] ID_MAX = 63'd6148914691236517204;

    // current orientation of the sub-quadrant: coordinates swapped and/or inverted
    typedef struct packed {
        logic swap;
        logic inv;
    } orient_t;

    // count of tiles at all lower zooms: (4^z - 1) / 3, one set bit per lower zoom
    function automatic logic [SUM_W-1:0] lower_count(input logic [ZOOM_W-1:0] z);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int k = 0; k < SUM_W / 2; k++)
        begin
            r[2*k] = (ZOOM_W'(k) < z);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/hilbert_tile_id.sv
// top level of the hilbert tile id pipeline
// depends on htid_pkg, htid_prep, htid_level_stage, htid_sum
`timescale 1ns / 1ps
`default_nettype none

// hilbert_tile_id maps a map tile (zoom, tile_col, tile_row) to a single tile
// id: the number of tiles at all lower zooms plus the hilbert-curve distance of
// the tile inside its 2^zoom grid. zoom above MAX_ZOOM saturates, and column
// and row bits at or above the zoom are ignored. the block is a fully
// pipelined pure function: one beat may enter every cycle while in_stall is
// low, and every accepted beat yields exactly one result beat, in order. the
// pipeline is one input register (zoom clamp, masking), four level stages
// that each resolve ceil(MAX_ZOOM/4) bit levels of the curve walk, and one
// output register holding the final 64-bit add. each stage has its own
// valid bit and moves whenever the next one is empty or moving, so bubbles
// fill in under a stall and nothing is lost or repeated. reset clears only
// the valid bits.

module hilbert_tile_id
    import htid_pkg::*;
#(
    parameter int MAX_ZOOM = 31
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [ZOOM_W-1:0]  zoom,
    input  wire logic [COORD_W-1:0] tile_col,
    input  wire logic [COORD_W-1:0] tile_row,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [ID_W-1:0]         tile_id
);

    // bit levels per stage, and the padded coordinate width they cover
    localparam int LPS = (MAX_ZOOM + STAGES - 1) / STAGES;
    localparam int W   = LPS * STAGES;

    // inter-stage buses; index 0 is the input register output
    logic               v_s   [0:STAGES];
    logic               st_s  [0:STAGES];
    logic [ZOOM_W-1:0]  z_s   [0:STAGES];
    logic [W-1:0]       x_s   [0:STAGES];
    logic [W-1:0]       y_s   [0:STAGES];
    orient_t            ctl_s [0:STAGES];
    logic [2*W-1:0]     d_s   [0:STAGES];

    // nothing resolved before the first level stage
    assign d_s[0] = '0;

    htid_prep #(
        .MAX_ZOOM (MAX_ZOOM),
        .W        (W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .zoom      (zoom),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .out_valid (v_s[0]),
        .out_stall (st_s[0]),
        .out_z     (z_s[0]),
        .out_x     (x_s[0]),
        .out_y     (y_s[0]),
        .out_ctl   (ctl_s[0])
    );

    // curve walk, top bit level first, LPS levels per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_level
        htid_level_stage #(
            .W      (W),
            .HI_BIT (W - 1 - k * LPS),
            .NLVL   (LPS)
        ) u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_s[k]),
            .in_stall  (st_s[k]),
            .in_z      (z_s[k]),
            .in_x      (x_s[k]),
            .in_y      (y_s[k]),
            .in_ctl    (ctl_s[k]),
            .in_d      (d_s[k]),
            .out_valid (v_s[k+1]),
            .out_stall (st_s[k+1]),
            .out_z     (z_s[k+1]),
            .out_x     (x_s[k+1]),
            .out_y     (y_s[k+1]),
            .out_ctl   (ctl_s[k+1]),
            .out_d     (d_s[k+1])
        );
    end

    // lower-zoom count plus distance, registered at the output
    htid_sum #(
        .W (W)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_s[STAGES]),
        .in_stall  (st_s[STAGES]),
        .in_z      (z_s[STAGES]),
        .in_d      (d_s[STAGES]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tile_id   (tile_id)
    );

endmodule

`default_nettype wire

### hdl/htid_prep.sv
// input register: zoom saturation, coordinate masking, initial orientation
// depends on htid_pkg
`timescale 1ns / 1ps
`default_nettype none

module htid_prep
    import htid_pkg::*;
#(
    parameter int MAX_ZOOM = 31,
    parameter int W        = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [ZOOM_W-1:0]  zoom,
    input  wire logic [COORD_W-1:0] tile_col,
    input  wire logic [COORD_W-1:0] tile_row,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [ZOOM_W-1:0]       out_z,
    output logic [W-1:0]            out_x,
    output logic [W-1:0]            out_y,
    output orient_t                 out_ctl
);

    localparam logic [ZOOM_W-1:0] ZMAX = ZOOM_W'(MAX_ZOOM);
    localparam logic              W_ODD = 1'(W % 2);

    logic                valid_reg;
    logic [ZOOM_W-1:0]   z_reg, z_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        y_reg, y_next;
    orient_t             ctl_reg, ctl_next;
    logic [COORD_W:0]    col_ext, row_ext;
    logic                ready;

    assign ready    = !valid_reg || !out_stall;
    assign in_stall = !ready;

    always_comb
    begin
        col_ext = {1'b0, tile_col};
        row_ext = {1'b0, tile_row};
        z_next  = (zoom > ZMAX) ? ZMAX : zoom;
        for (int k = 0; k < W; k++)
        begin
            x_next[k] = col_ext[k] & (ZOOM_W'(k) < z_next);
            y_next[k] = row_ext[k] & (ZOOM_W'(k) < z_next);
        end
        // levels above the zoom see zero bits and only swap
        ctl_next.swap = W_ODD ^ z_next[0];
        ctl_next.inv  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            z_reg   <= z_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_z     = z_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ctl   = ctl_reg;

    a_zoom_sat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (z_reg <= ZMAX))
        else $error("zoom not saturated");

    a_no_inv_start: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !ctl_reg.inv)
        else $error("initial orientation inverted");

    a_col_masked: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((x_reg >> z_reg) == '0) && ((y_reg >> z_reg) == '0))
        else $error("coordinate bits above zoom survive");

endmodule

`default_nettype wire

### hdl/htid_level_stage.sv
// one pipeline stage resolving a group of hilbert bit levels
// depends on htid_pkg
`timescale 1ns / 1ps
`default_nettype none

module htid_level_stage
    import htid_pkg::*;
#(
    parameter int W      = 32,
    parameter int HI_BIT = 31,
    parameter int NLVL   = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ZOOM_W-1:0] in_z,
    input  wire logic [W-1:0]      in_x,
    input  wire logic [W-1:0]      in_y,
    input  wire orient_t           in_ctl,
    input  wire logic [2*W-1:0]    in_d,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ZOOM_W-1:0]      out_z,
    output logic [W-1:0]           out_x,
    output logic [W-1:0]           out_y,
    output orient_t                out_ctl,
    output logic [2*W-1:0]         out_d
);

    logic               valid_reg;
    logic [ZOOM_W-1:0]  z_reg;
    logic [W-1:0]       x_reg;
    logic [W-1:0]       y_reg;
    orient_t            ctl_reg, ctl_next;
    logic [2*W-1:0]     d_reg, d_next;
    logic               ready;

    assign ready    = !valid_reg || !out_stall;
    assign in_stall = !ready;

    always_comb
    begin
        int  b;
        logic rx;
        logic ry;
        ctl_next = in_ctl;
        d_next   = in_d;
        for (int j = 0; j < NLVL; j++)
        begin
            b  = HI_BIT - j;
            rx = (ctl_next.swap ? in_y[b] : in_x[b]) ^ ctl_next.inv;
            ry = (ctl_next.swap ? in_x[b] : in_y[b]) ^ ctl_next.inv;
            // quadrant code (3*rx)^ry lands in its own bit pair
            d_next[2*b +: 2] = {rx, rx ^ ry};
            if (!ry)
            begin
                ctl_next.inv  = ctl_next.inv ^ rx;
                ctl_next.swap = !ctl_next.swap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            z_reg   <= in_z;
            x_reg   <= in_x;
            y_reg   <= in_y;
            ctl_reg <= ctl_next;
            d_reg   <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_z     = z_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ctl   = ctl_reg;
    assign out_d     = d_reg;

    a_d_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((d_reg >> {z_reg, 1'b0}) == '0))
        else $error("distance bits above the zoom grid");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(d_reg) && $stable(z_reg)))
        else $error("stalled stage lost its contents");

    a_zero_zoom: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (z_reg == '0)) |-> (d_reg == '0) && !ctl_reg.inv)
        else $error("zero zoom produced a nonzero distance");

endmodule

`default_nettype wire

### hdl/htid_sum.sv
// output stage: adds the lower-zoom tile count to the hilbert distance
// depends on htid_pkg
`timescale 1ns / 1ps
`default_nettype none

module htid_sum
    import htid_pkg::*;
#(
    parameter int W = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ZOOM_W-1:0] in_z,
    input  wire logic [2*W-1:0]    in_d,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ID_W-1:0]        tile_id
);

    logic               valid_reg;
    logic [ZOOM_W-1:0]  z_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SUM_W-1:0]   id_next;
    logic               ready;

    assign ready    = !valid_reg || !out_stall;
    assign in_stall = !ready;
    assign id_next  = SUM_W'(in_d) + lower_count(in_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            z_reg  <= in_z;
            id_reg <= id_next[ID_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign tile_id   = id_reg;

    a_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (id_reg <= ID_MAX))
        else $error("tile id beyond the largest id");

    a_id_zoom0: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (z_reg == '0)) |-> (id_reg == '0))
        else $error("zoom zero must give id zero");

    a_id_floor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (SUM_W'(id_reg) >= lower_count(z_reg)))
        else $error("tile id below the lower-zoom count");

endmodule

`default_nettype wire

### bench/hilbert_tile_id_tb.sv
// self-checking bench for hilbert_tile_id: random idling on both channels, in-order id checks
// depends on htid_pkg and hilbert_tile_id
`timescale 1ns / 1ps

module hilbert_tile_id_tb;
    import htid_pkg::*;

    localparam int MAX_ZOOM   = 31;
    localparam int IDLE_PCT   = 38;
    localparam int SETTLE_CYC = 12;   // pipeline is 6 deep

    // one tile request as it goes into the block
    typedef struct packed {
        logic [ZOOM_W-1:0]  z;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } tile_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ZOOM_W-1:0]  zoom = '0;
    logic [COORD_W-1:0] tile_col = '0;
    logic [COORD_W-1:0] tile_row = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ID_W-1:0]    tile_id;

    tile_req_t       req_q[$];       // tile requests not yet offered
    logic [ID_W-1:0] ids_due[$];     // predicted ids of accepted requests, oldest first
    tile_req_t       next_req;
    logic [ID_W-1:0] want_id;
    logic            calm = 1'b0;    // while set neither side idles
    int              errors = 0;
    int              beats_in = 0;
    int              beats_out = 0;
    int              deep_zoom_beats = 0;

    hilbert_tile_id #(
        .MAX_ZOOM (MAX_ZOOM)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .zoom      (zoom),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tile_id   (tile_id)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // tile id predictor: tiles at all lower zooms plus the hilbert distance,
    // walked from the top bit level down, reflecting and swapping per quadrant
    function automatic logic [ID_W-1:0] tile_id_of(input logic [ZOOM_W-1:0] z_in,
                                                   input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
        int          zl;
        logic [31:0] mask;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        logic [63:0] below;
        logic [63:0] hdist;
        logic        rx;
        logic        ry;
        zl = (int'(z_in) > MAX_ZOOM) ? MAX_ZOOM : int'(z_in);
        below = ((64'd1 << (2 * zl)) - 64'd1) / 64'd3;
        mask = 32'((64'd1 << zl) - 64'd1);
        x = {1'b0, col} & mask;
        y = {1'b0, row} & mask;
        hdist = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (b < zl)
            begin
                rx = x[b];
                ry = y[b];
                // quadrant code is 0, 1, 3, 2 for (rx, ry) = 00, 01, 10, 11
                hdist = hdist + ({62'd0, rx, rx ^ ry} << (2 * b));
                if (!ry)
                begin
                    if (rx)
                    begin
                        x = ~x & mask;
                        y = ~y & mask;
                    end
                    t = x;
                    x = y;
                    y = t;
                end
            end
        end
        return ID_W'(below + hdist);
    endfunction

    task automatic note_error(input string what, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d (%s): expected tile_id %0d, got %0d",
                     errors, what, want, got);
    endtask

    // driver: offers queued requests, holds a stalled beat, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            zoom     <= '0;
            tile_col <= '0;
            tile_row <= '0;
        end
        else
        begin
            // beat taken at this edge: predict its id now, while the payload is still up
            if (in_valid && !in_stall)
            begin
                ids_due.push_back(tile_id_of(zoom, tile_col, tile_row));
                beats_in++;
                if (zoom >= ZOOM_W'(24))
                    deep_zoom_beats++;
            end
            // payload may only move once the current beat is gone
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_req = req_q.pop_front();
                    in_valid <= 1'b1;
                    zoom     <= next_req.z;
                    tile_col <= next_req.col;
                    tile_row <= next_req.row;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks every result beat against the oldest prediction,
    // and stalls the result channel at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (ids_due.size() == 0)
                    note_error("result with nothing pending", '0, tile_id);
                else
                begin
                    want_id = ids_due.pop_front();
                    if (tile_id !== want_id)
                        note_error("tile_id", want_id, tile_id);
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic push_req(input logic [ZOOM_W-1:0] z, input logic [COORD_W-1:0] col,
                            input logic [COORD_W-1:0] row);
        tile_req_t r;
        r.z = z;
        r.col = col;
        r.row = row;
        req_q.push_back(r);
    endtask

    // mostly real tiles inside the grid, the rest with junk in the high bits
    task automatic push_random_reqs(input int count);
        logic [ZOOM_W-1:0]  z;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] mask;
        int                 pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                z = ZOOM_W'(MAX_ZOOM);
            else if (pick < 30)
                z = ZOOM_W'($urandom_range(0, 4));
            else
                z = ZOOM_W'($urandom_range(0, 31));
            col = COORD_W'($urandom);
            row = COORD_W'($urandom);
            if ($urandom_range(0, 99) < 60)
            begin
                mask = COORD_W'((64'd1 << z) - 64'd1);
                col = col & mask;
                row = row & mask;
            end
            push_req(z, col, row);
        end
    endtask

    // sender holds off until the pipeline has given back every result
    task automatic wait_drained();
        @(negedge clk);
        while (req_q.size() != 0 || in_valid || ids_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zoom 0 ignores everything, extremes at full depth,
        // every quadrant at zoom 1, high coordinate bits that must be ignored
        push_req(5'd0, '1, '1);
        push_req(5'd0, '0, '0);
        push_req(5'd31, '0, '0);
        push_req(5'd31, '1, '1);
        push_req(5'd31, '1, '0);           // last tile on the curve, largest id
        push_req(5'd31, '0, '1);
        push_req(5'd1, 31'd0, 31'd0);
        push_req(5'd1, 31'd0, 31'd1);
        push_req(5'd1, 31'd1, 31'd1);
        push_req(5'd1, 31'd1, 31'd0);
        push_req(5'd3, 31'h7fff_fff8 | 31'd5, 31'h7fff_fff8 | 31'd2);
        push_req(5'd3, 31'd5, 31'd2);
        push_req(5'd2, 31'h7fff_fffc, 31'h4000_0000);
        push_req(5'd31, 31'h5555_5555, 31'h2aaa_aaaa);
        push_req(5'd31, 31'h2aaa_aaaa, 31'h5555_5555);
        push_req(5'd30, '1, '1);
        push_req(5'd30, 31'h4000_0000, 31'h4000_0000);
        push_req(5'd16, 31'h0000_ffff, 31'h0000_8000);
        push_req(5'd17, 31'h0001_0000, 31'h0000_0001);
        push_req(5'd8, 31'd200, 31'd55);
        wait_drained();

        push_random_reqs(800);
        wait_drained();

        // a long stretch with both sides always ready
        calm = 1'b1;
        push_random_reqs(300);
        wait_drained();
        calm = 1'b0;

        push_random_reqs(600);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        while (ids_due.size() > 0)
            note_error("result never came", ids_due.pop_front(), '0);
        if (errors > 10)
            $display("%0d further mismatches not shown", errors - 10);

        $display("checked %0d tile ids from %0d request beats, %0d of them at zoom 24 and up",
                 beats_out, beats_in, deep_zoom_beats);
        $display("zooms 0 to 31 with junk high coordinate bits, random idling and a no-idle stretch");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("timeout: %0d beats in, %0d beats out", beats_in, beats_out);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
